// ===== rtl/core/config_script_lexer_core_defines.svh =====
// Assertion macros shared by the lexer RTL.
`ifndef CONFIG_SCRIPT_LEXER_CORE_DEFINES_SVH
`define CONFIG_SCRIPT_LEXER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked at every rising edge outside reset.
`define CLX_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every rising edge, reset included.
`define CLX_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CLX_ASSERT(name, clk, rst_n, prop, msg)
`define CLX_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// ===== rtl/core/clx_pkg.sv =====
`timescale 1ns / 1ps

package clx_pkg;

  localparam int unsigned COLUMN_BITS_DEF = 12;
  localparam int unsigned LINE_BITS_DEF   = 16;
  localparam int unsigned MAX_RESULTS     = 3;
  localparam int unsigned QUEUE_DEPTH     = 4;

  typedef enum logic [1:0] {
    EV_TEXT  = 2'd0,
    EV_DONE  = 2'd1,
    EV_ERROR = 2'd2
  } event_e;

  localparam logic [3:0] TK_NAME        = 4'd0;
  localparam logic [3:0] TK_NUMBER      = 4'd1;
  localparam logic [3:0] TK_STRING      = 4'd2;
  localparam logic [3:0] TK_DOT         = 4'd3;
  localparam logic [3:0] TK_BANG        = 4'd4;
  localparam logic [3:0] TK_BRACE_OPEN  = 4'd5;
  localparam logic [3:0] TK_BRACE_CLOSE = 4'd6;
  localparam logic [3:0] TK_PAREN_OPEN  = 4'd7;
  localparam logic [3:0] TK_PAREN_CLOSE = 4'd8;

  localparam logic ERR_QUOTE  = 1'b0;
  localparam logic ERR_SYMBOL = 1'b1;

  // Column select of a result: the token start column, or the current column.
  localparam logic SEL_TOKEN   = 1'b0;
  localparam logic SEL_CURRENT = 1'b1;

  localparam logic [7:0] CH_NUL         = 8'h00;
  localparam logic [7:0] CH_SPACE       = 8'h20;
  localparam logic [7:0] CH_TAB         = 8'h09;
  localparam logic [7:0] CH_CR          = 8'h0d;
  localparam logic [7:0] CH_HASH        = 8'h23;
  localparam logic [7:0] CH_BRACE_OPEN  = 8'h7b;
  localparam logic [7:0] CH_BRACE_CLOSE = 8'h7d;
  localparam logic [7:0] CH_PAREN_OPEN  = 8'h28;
  localparam logic [7:0] CH_PAREN_CLOSE = 8'h29;
  localparam logic [7:0] CH_DOT         = 8'h2e;
  localparam logic [7:0] CH_BANG        = 8'h21;
  localparam logic [7:0] CH_MINUS       = 8'h2d;
  localparam logic [7:0] CH_UNDERSCORE  = 8'h5f;
  localparam logic [7:0] CH_X_LOW       = 8'h78;
  localparam logic [7:0] CH_X_UP        = 8'h58;
  localparam logic [7:0] CH_O_LOW       = 8'h6f;
  localparam logic [7:0] CH_O_UP        = 8'h4f;
  localparam logic [7:0] CH_QUEST       = 8'h3f;
  localparam logic [7:0] CH_DQUOTE      = 8'h22;
  localparam logic [7:0] CH_SQUOTE      = 8'h27;

  typedef struct packed {
    event_e     event_kind;
    logic [3:0] token_kind;
    logic [7:0] text_byte;
    logic       error_code;
    logic       col_sel;
  } slot_t;

  // All results caused by one character; count is 1 to MAX_RESULTS.
  typedef struct packed {
    logic [1:0]                   count;
    slot_t [MAX_RESULTS-1:0]      slots;
  } bundle_t;

  function automatic slot_t mk_slot(event_e ev, logic [3:0] tk, logic [7:0] b, logic err,
                                    logic sel);
    slot_t s;
    s.event_kind = ev;
    s.token_kind = tk;
    s.text_byte  = b;
    s.error_code = err;
    s.col_sel    = sel;
    return s;
  endfunction

endpackage

// ===== rtl/core/clx_front.sv =====
`timescale 1ns / 1ps

module clx_front import clx_pkg::*; #(
  parameter int unsigned COLUMN_BITS = COLUMN_BITS_DEF,
  parameter int unsigned LINE_BITS   = LINE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [7:0]             char_byte_i,
  input  logic                   line_end_i,
  input  logic                   source_start_i,
  output logic                   push_o,
  output bundle_t                bundle_o,
  output logic [LINE_BITS-1:0]   line_o,
  output logic [COLUMN_BITS-1:0] tok_col_o,
  output logic [COLUMN_BITS-1:0] col_o
);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_COMMENT,
    MODE_NAME,
    MODE_NUMBER,
    MODE_MINUS,
    MODE_STRING,
    MODE_FAILED
  } mode_e;

  mode_e                  mode_q, mode_d;
  logic                   quote_q, quote_d;
  logic [LINE_BITS-1:0]   line_q, line_d, line_base;
  logic [COLUMN_BITS-1:0] col_q, col_d, col_base;
  logic [COLUMN_BITS-1:0] tok_col_q, tok_col_d, tok_base;
  logic                   cut_q, cut_d;
  logic                   do_classify;
  logic                   tok_sel;
  logic [1:0]             n;
  slot_t [MAX_RESULTS-1:0] slots;
  logic [7:0]             c;
  logic [7:0]             quote_char;

  function automatic logic is_digit(logic [7:0] ch);
    return ch >= 8'h30 && ch <= 8'h39;
  endfunction

  function automatic logic is_alpha(logic [7:0] ch);
    return (ch >= 8'h61 && ch <= 8'h7a) || (ch >= 8'h41 && ch <= 8'h5a);
  endfunction

  function automatic logic is_space(logic [7:0] ch);
    return ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR);
  endfunction

  function automatic logic is_name_body(logic [7:0] ch);
    return is_alpha(ch) || is_digit(ch) || ch == CH_UNDERSCORE || ch == CH_BANG ||
           ch == CH_MINUS || ch == CH_QUEST || ch == CH_NUL;
  endfunction

  function automatic logic is_number_body(logic [7:0] ch);
    return is_digit(ch) || (ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46) ||
           ch == CH_DOT || ch == CH_O_LOW || ch == CH_O_UP || ch == CH_X_LOW ||
           ch == CH_X_UP || ch == CH_MINUS;
  endfunction

  always_comb begin
    c = char_byte_i;
    if (source_start_i) begin
      mode_d    = MODE_IDLE;
      quote_d   = 1'b0;
      line_base = LINE_BITS'(1);
      col_base  = '0;
      tok_base  = '0;
      cut_d     = 1'b0;
    end else begin
      mode_d    = mode_q;
      quote_d   = quote_q;
      line_base = line_q;
      col_base  = col_q;
      tok_base  = tok_col_q;
      cut_d     = cut_q;
    end
    line_d      = line_base;
    col_d       = col_base;
    tok_col_d   = tok_base;
    quote_char  = quote_d ? CH_SQUOTE : CH_DQUOTE;
    do_classify = 1'b0;
    tok_sel     = SEL_TOKEN;
    n           = '0;
    slots       = '0;

    if (mode_d != MODE_FAILED) begin
      case (mode_d)
        MODE_COMMENT: begin
        end
        MODE_NAME: begin
          if (is_name_body(c)) begin
            if (c == CH_NUL) begin
              cut_d = 1'b1;
            end else if (!cut_d) begin
              slots[n] = mk_slot(EV_TEXT, TK_NAME, c, 1'b0, tok_sel);
              n = n + 2'd1;
            end
          end else begin
            slots[n] = mk_slot(EV_DONE, TK_NAME, '0, 1'b0, tok_sel);
            n = n + 2'd1;
            mode_d = MODE_IDLE;
            do_classify = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (is_number_body(c)) begin
            slots[n] = mk_slot(EV_TEXT, TK_NUMBER, c, 1'b0, tok_sel);
            n = n + 2'd1;
          end else begin
            slots[n] = mk_slot(EV_DONE, TK_NUMBER, '0, 1'b0, tok_sel);
            n = n + 2'd1;
            mode_d = MODE_IDLE;
            do_classify = 1'b1;
          end
        end
        MODE_MINUS: begin
          if (is_digit(c)) begin
            slots[n] = mk_slot(EV_TEXT, TK_NUMBER, CH_MINUS, 1'b0, tok_sel);
            n = n + 2'd1;
            slots[n] = mk_slot(EV_TEXT, TK_NUMBER, c, 1'b0, tok_sel);
            n = n + 2'd1;
            mode_d = MODE_NUMBER;
          end else begin
            slots[n] = mk_slot(EV_ERROR, '0, '0, ERR_SYMBOL, tok_sel);
            n = n + 2'd1;
            mode_d = MODE_FAILED;
          end
        end
        MODE_STRING: begin
          if (c == quote_char) begin
            slots[n] = mk_slot(EV_DONE, TK_STRING, '0, 1'b0, tok_sel);
            n = n + 2'd1;
            mode_d = MODE_IDLE;
          end else if (c == CH_NUL) begin
            cut_d = 1'b1;
          end else if (!cut_d) begin
            slots[n] = mk_slot(EV_TEXT, TK_STRING, c, 1'b0, tok_sel);
            n = n + 2'd1;
          end
        end
        default: begin
          mode_d = MODE_IDLE;
          do_classify = 1'b1;
        end
      endcase

      // A non-space character outside any token, other than '#', starts a new one at the current column.
      if (do_classify && !is_space(c)) begin
        if (c == CH_HASH) begin
          mode_d = MODE_COMMENT;
        end else begin
          tok_col_d = col_base;
          cut_d     = 1'b0;
          tok_sel   = SEL_CURRENT;
          if (is_alpha(c) || c == CH_UNDERSCORE) begin
            mode_d = MODE_NAME;
            slots[n] = mk_slot(EV_TEXT, TK_NAME, c, 1'b0, tok_sel);
            n = n + 2'd1;
          end else if (is_digit(c)) begin
            mode_d = MODE_NUMBER;
            slots[n] = mk_slot(EV_TEXT, TK_NUMBER, c, 1'b0, tok_sel);
            n = n + 2'd1;
          end else if (c == CH_MINUS) begin
            mode_d = MODE_MINUS;
          end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
            mode_d  = MODE_STRING;
            quote_d = (c == CH_SQUOTE);
          end else if (c == CH_DOT) begin
            slots[n] = mk_slot(EV_DONE, TK_DOT, '0, 1'b0, tok_sel);
            n = n + 2'd1;
          end else if (c == CH_BANG) begin
            slots[n] = mk_slot(EV_DONE, TK_BANG, '0, 1'b0, tok_sel);
            n = n + 2'd1;
          end else if (c == CH_BRACE_OPEN) begin
            slots[n] = mk_slot(EV_DONE, TK_BRACE_OPEN, '0, 1'b0, tok_sel);
            n = n + 2'd1;
          end else if (c == CH_BRACE_CLOSE) begin
            slots[n] = mk_slot(EV_DONE, TK_BRACE_CLOSE, '0, 1'b0, tok_sel);
            n = n + 2'd1;
          end else if (c == CH_PAREN_OPEN) begin
            slots[n] = mk_slot(EV_DONE, TK_PAREN_OPEN, '0, 1'b0, tok_sel);
            n = n + 2'd1;
          end else if (c == CH_PAREN_CLOSE) begin
            slots[n] = mk_slot(EV_DONE, TK_PAREN_CLOSE, '0, 1'b0, tok_sel);
            n = n + 2'd1;
          end else begin
            slots[n] = mk_slot(EV_ERROR, '0, '0, ERR_SYMBOL, tok_sel);
            n = n + 2'd1;
            mode_d = MODE_FAILED;
          end
        end
      end

      if (mode_d != MODE_FAILED) begin
        if (line_end_i) begin
          case (mode_d)
            MODE_NAME: begin
              slots[n] = mk_slot(EV_DONE, TK_NAME, '0, 1'b0, tok_sel);
              n = n + 2'd1;
            end
            MODE_NUMBER: begin
              slots[n] = mk_slot(EV_DONE, TK_NUMBER, '0, 1'b0, tok_sel);
              n = n + 2'd1;
            end
            MODE_MINUS: begin
              slots[n] = mk_slot(EV_ERROR, '0, '0, ERR_SYMBOL, tok_sel);
              n = n + 2'd1;
            end
            MODE_STRING: begin
              slots[n] = mk_slot(EV_ERROR, '0, '0, ERR_QUOTE, tok_sel);
              n = n + 2'd1;
            end
            default: begin
            end
          endcase
          if (mode_d == MODE_MINUS || mode_d == MODE_STRING) begin
            mode_d = MODE_FAILED;
          end else begin
            mode_d = MODE_IDLE;
            line_d = line_base + LINE_BITS'(1);
            col_d  = '0;
          end
        end else if (col_base != {COLUMN_BITS{1'b1}}) begin
          col_d = col_base + COLUMN_BITS'(1);
        end
      end
    end
  end

  assign push_o         = valid_i && (n != 2'd0);
  assign bundle_o.count = n;
  assign bundle_o.slots = slots;
  assign line_o         = line_base;
  assign tok_col_o      = tok_base;
  assign col_o          = col_base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      quote_q   <= 1'b0;
      line_q    <= LINE_BITS'(1);
      col_q     <= '0;
      tok_col_q <= '0;
      cut_q     <= 1'b0;
    end else if (valid_i) begin
      mode_q    <= mode_d;
      quote_q   <= quote_d;
      line_q    <= line_d;
      col_q     <= col_d;
      tok_col_q <= tok_col_d;
      cut_q     <= cut_d;
    end
  end

endmodule

// ===== rtl/core/clx_fifo.sv =====
`timescale 1ns / 1ps

module clx_fifo import clx_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/core/clx_back.sv =====
`timescale 1ns / 1ps

module clx_back import clx_pkg::*; #(
  parameter int unsigned COLUMN_BITS = COLUMN_BITS_DEF,
  parameter int unsigned LINE_BITS   = LINE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   avail_i,
  input  bundle_t                bundle_i,
  input  logic [LINE_BITS-1:0]   line_i,
  input  logic [COLUMN_BITS-1:0] tok_col_i,
  input  logic [COLUMN_BITS-1:0] col_i,
  output logic                   take_o,
  input  logic                   pop_i,
  output logic                   empty_o,
  output logic [1:0]             event_kind_o,
  output logic [3:0]             token_kind_o,
  output logic [7:0]             text_byte_o,
  output logic [LINE_BITS-1:0]   line_number_o,
  output logic [COLUMN_BITS-1:0] start_column_o,
  output logic                   error_code_o,
  output logic                   last_result_o
);

  logic                   valid_q;
  logic [1:0]             idx_q;
  logic                   load;
  logic                   last;
  slot_t                  cur;
  logic [1:0]             event_q;
  logic [3:0]             token_q;
  logic [7:0]             byte_q;
  logic [LINE_BITS-1:0]   line_q;
  logic [COLUMN_BITS-1:0] column_q;
  logic                   err_q;
  logic                   last_q;

  // The output register refills in the same cycle as its result transfers.
  assign load   = avail_i && (!valid_q || pop_i);
  assign cur    = bundle_i.slots[idx_q];
  assign last   = (idx_q == bundle_i.count - 2'd1);
  assign take_o = load && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= last ? 2'd0 : idx_q + 2'd1;
      end else if (pop_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      event_q  <= cur.event_kind;
      token_q  <= cur.token_kind;
      byte_q   <= cur.text_byte;
      line_q   <= line_i;
      column_q <= (cur.col_sel == SEL_CURRENT) ? col_i : tok_col_i;
      err_q    <= cur.error_code;
      last_q   <= last;
    end
  end

  assign empty_o        = !valid_q;
  assign event_kind_o   = event_q;
  assign token_kind_o   = token_q;
  assign text_byte_o    = byte_q;
  assign line_number_o  = line_q;
  assign start_column_o = column_q;
  assign error_code_o   = err_q;
  assign last_result_o  = last_q;

endmodule

// ===== rtl/core/config_script_lexer_core.sv =====
// Streaming lexer for a small configuration script language.
// Input channel: one source character per transfer (push/full), with a flag
// for the last character of a line and a flag that restarts the source.
// Result channel (empty/pop): token text bytes, token-complete events with
// line and start column, and error events; last_result_o marks the final
// result caused by one character, which may cause none or up to three.
// The front stage classifies a character in the cycle it is accepted and
// writes its results as one entry into a four-entry queue. The back stage
// moves one result per cycle into the output register while it is empty or
// popped; a character's results go from the queue entry to that register.
// Characters are taken at one per cycle while the queue has room; results
// leave at one per cycle while pop is held, so sustained input runs at
// one character per cycle when each character causes at most one result
// on average. When the receiver stalls, the output register holds and the
// queue fills; full rises once all four entries are taken.
// Reset clears the queue and output register, sets the line count to one
// and the column to zero. After an error the lexer stays silent until a
// character arrives with source_start_i set.
`timescale 1ns / 1ps
`include "config_script_lexer_core_defines.svh"

module config_script_lexer_core import clx_pkg::*; #(
  parameter int unsigned COLUMN_BITS = COLUMN_BITS_DEF,
  parameter int unsigned LINE_BITS   = LINE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  logic [7:0]             char_byte_i,
  input  logic                   line_end_i,
  input  logic                   source_start_i,
  output logic                   empty,
  input  logic                   pop,
  output logic [1:0]             event_kind_o,
  output logic [3:0]             token_kind_o,
  output logic [7:0]             text_byte_o,
  output logic [LINE_BITS-1:0]   line_number_o,
  output logic [COLUMN_BITS-1:0] start_column_o,
  output logic                   error_code_o,
  output logic                   last_result_o
);

  localparam int unsigned ENTRY_W = $bits(bundle_t) + LINE_BITS + 2 * COLUMN_BITS;

  logic                   accept;
  logic                   f_push;
  bundle_t                f_bundle;
  logic [LINE_BITS-1:0]   f_line;
  logic [COLUMN_BITS-1:0] f_tok_col;
  logic [COLUMN_BITS-1:0] f_col;
  logic [ENTRY_W-1:0]     q_wdata, q_rdata;
  logic                   q_full, q_empty, q_take;
  bundle_t                b_bundle;
  logic [LINE_BITS-1:0]   b_line;
  logic [COLUMN_BITS-1:0] b_tok_col;
  logic [COLUMN_BITS-1:0] b_col;

  assign full   = q_full;
  assign accept = push && !q_full;

  clx_front #(
    .COLUMN_BITS(COLUMN_BITS),
    .LINE_BITS  (LINE_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (accept),
    .char_byte_i   (char_byte_i),
    .line_end_i    (line_end_i),
    .source_start_i(source_start_i),
    .push_o        (f_push),
    .bundle_o      (f_bundle),
    .line_o        (f_line),
    .tok_col_o     (f_tok_col),
    .col_o         (f_col)
  );

  assign q_wdata = {f_bundle, f_line, f_tok_col, f_col};
  assign {b_bundle, b_line, b_tok_col, b_col} = q_rdata;

  clx_fifo #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (f_push),
    .wdata_i(q_wdata),
    .pop_i  (q_take),
    .rdata_o(q_rdata),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  clx_back #(
    .COLUMN_BITS(COLUMN_BITS),
    .LINE_BITS  (LINE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .avail_i       (!q_empty),
    .bundle_i      (b_bundle),
    .line_i        (b_line),
    .tok_col_i     (b_tok_col),
    .col_i         (b_col),
    .take_o        (q_take),
    .pop_i         (pop),
    .empty_o       (empty),
    .event_kind_o  (event_kind_o),
    .token_kind_o  (token_kind_o),
    .text_byte_o   (text_byte_o),
    .line_number_o (line_number_o),
    .start_column_o(start_column_o),
    .error_code_o  (error_code_o),
    .last_result_o (last_result_o)
  );

  `CLX_ASSERT(a_entry_not_blank, clk_i, rst_ni, f_push |-> f_bundle.count != 2'd0, "blank entry")
  `CLX_ASSERT(a_take_when_avail, clk_i, rst_ni, q_take |-> !q_empty, "take from empty queue")
  `CLX_ASSERT(a_take_marks_last, clk_i, rst_ni, q_take |=> !empty && last_result_o, "no last flag")
  `CLX_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> empty, "result shown during reset")

endmodule
